[src/ccgc_pkg.sv]
// Shared types and constants for the cosine column gain correction block.
// Used by the cosine pipeline and the top module; has no dependencies of its own.
package ccgc_pkg;

  localparam int PIX_W    = 8;
  localparam int COL_W    = 13;
  localparam int CFG_W    = 16;
  localparam int LW_W     = 14;
  localparam int AW_W     = 16;
  localparam int D_W      = 13;
  localparam int NUM_W    = 31;
  localparam int PHASE_QW = 17;
  localparam int G_W      = 17;
  localparam int MGAIN_W  = 20;
  localparam int GAIN_W   = 24;
  localparam int GAIN_QW  = 24;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;

  // Line widths above this saturate to it.
  localparam int MAX_LINE_WIDTH = 8192;
  localparam int LW_LIMIT = (MAX_LINE_WIDTH > (2 ** LW_W) - 1) ? (2 ** LW_W) - 1
                                                                : MAX_LINE_WIDTH;

  localparam logic [GAIN_W-1:0] GAIN_MAX = 24'hFF_FFFF;
  localparam logic [PIX_W-1:0]  PIX_MAX  = 8'hFF;

  // Horner coefficients of the quarter-wave cosine in Q30, innermost first.
  localparam logic signed [31:0] COS_COEF [6] = '{
    32'sd27058, 32'sd987047, 32'sd22401991,
    32'sd272375560, 32'sd1324675879, 32'sd1073741824
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STRENGTH     = 3'd0,
    REG_WIDTH        = 3'd1,
    REG_START_COLUMN = 3'd2,
    REG_END_COLUMN   = 3'd3,
    REG_LINE_WIDTH   = 3'd4
  } cfg_reg_t;

  // Travels alongside the phase divider and the cosine pipeline.
  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             bypass;
  } px_side_t;

  // Travels alongside the gain divider.
  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic               bypass;
    logic               sat;
    logic [MGAIN_W-1:0] mgain;
  } gain_side_t;

endpackage

[src/ccgc_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the divisor and a sideband word travel with each word.
module ccgc_div_pipe #(
  parameter int QW = 17,
  parameter int RW = 14,
  parameter int SW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [RW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [RW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  // The starting remainder must be below the divisor; each stage shifts in
  // one dividend bit from the top of wq and shifts one quotient bit in below.
  logic [QW-1:0] v_r;
  logic [RW-1:0] rem_r  [QW];
  logic [QW-1:0] wq_r   [QW];
  logic [RW-1:0] dv_r   [QW];
  logic [SW-1:0] side_r [QW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[QW-2:0], in_valid};
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [RW-1:0] rem_in;
    logic [QW-1:0] wq_in;
    logic [RW-1:0] dv_in;
    logic [SW-1:0] side_in;
    logic [RW:0]   rsh;
    logic [RW:0]   diff;
    logic          ge;
    logic [RW-1:0] rem_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = in_rem;
      assign wq_in   = in_low;
      assign dv_in   = in_div;
      assign side_in = in_side;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign wq_in   = wq_r[i-1];
      assign dv_in   = dv_r[i-1];
      assign side_in = side_r[i-1];
    end

    assign rsh     = {rem_in, wq_in[QW-1]};
    assign diff    = rsh - {1'b0, dv_in};
    assign ge      = (rsh >= {1'b0, dv_in});
    assign rem_nxt = ge ? diff[RW-1:0] : rsh[RW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        wq_r[i]   <= {wq_in[QW-2:0], ge};
        dv_r[i]   <= dv_in;
        side_r[i] <= side_in;
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_quo   = wq_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

[src/ccgc_cos_pipe.sv]
// Pipelined cosine of a phase in turns (Q0.16), result magnitude in Q16.
// Uses ccgc_pkg for the polynomial coefficients and widths.
module ccgc_cos_pipe
  import ccgc_pkg::*;
#(
  parameter int SW = 9
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [15:0]    in_p,
  input  logic [SW-1:0]  in_side,
  output logic           out_valid,
  output logic [G_W-1:0] out_g,
  output logic           out_pos,
  output logic [SW-1:0]  out_side
);

  // Stage 0 folds the phase into a quarter wave, stage 1 squares it, stages
  // 2 to 11 are five multiply/subtract Horner steps, stage 12 rounds.
  localparam int NS = 13;

  logic [NS-1:0]        v_r;
  logic [SW-1:0]        side_r [NS];
  logic [1:0]           q_r    [NS-1];
  logic [G_W-1:0]       z_r;
  logic [G_W-1:0]       z2_r   [1:9];
  logic signed [31:0]   prod_r [5];
  logic signed [31:0]   acc_r  [5];
  logic [G_W-1:0]       g_r;
  logic                 pos_r;

  logic [14:0]          r_flip;
  logic [G_W-1:0]       z_nxt;
  logic [2*G_W-1:0]     zz;
  logic signed [31:0]   mul_a    [5];
  logic signed [49:0]   prod_full [5];
  logic [30:0]          acc_c;
  logic [30:0]          acc_rnd;
  logic [G_W-1:0]       g_nxt;

  assign r_flip = 15'd16384 - {1'b0, in_p[13:0]};
  assign z_nxt  = in_p[14] ? {r_flip, 2'b00} : {1'b0, in_p[13:0], 2'b00};
  assign zz     = z_r * z_r;

  always_comb begin
    mul_a[0] = COS_COEF[0];
    for (int k = 1; k < 5; k++) begin
      mul_a[k] = acc_r[k-1];
    end
    for (int k = 0; k < 5; k++) begin
      prod_full[k] = mul_a[k] * $signed({1'b0, z2_r[2*k+1]});
    end
  end

  // The polynomial can dip just below zero at the end of the quarter wave.
  assign acc_c   = acc_r[4][31] ? '0 : acc_r[4][30:0];
  assign acc_rnd = acc_c + 31'd8192;
  assign g_nxt   = acc_rnd[30:14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      q_r[0]    <= in_p[15:14];
      z_r       <= z_nxt;
      z2_r[1]   <= zz[32:16];
      for (int i = 1; i < NS; i++) begin
        side_r[i] <= side_r[i-1];
      end
      for (int i = 1; i < NS - 1; i++) begin
        q_r[i] <= q_r[i-1];
      end
      for (int i = 2; i <= 9; i++) begin
        z2_r[i] <= z2_r[i-1];
      end
      for (int k = 0; k < 5; k++) begin
        prod_r[k] <= prod_full[k][47:16];
        acc_r[k]  <= COS_COEF[k+1] - prod_r[k];
      end
      g_r   <= g_nxt;
      pos_r <= (g_nxt != '0) && (q_r[NS-2][1] == q_r[NS-2][0]);
    end
  end

  assign out_valid = v_r[NS-1];
  assign out_g     = g_r;
  assign out_pos   = pos_r;
  assign out_side  = side_r[NS-1];

endmodule

[src/cosine_column_gain_correction.sv]
// Column gain correction with a cosine profile, for lens vignetting.
// Pipeline: five single register stages, the 17-stage phase divider, the 13-stage
// cosine and the 24-stage gain divider. Throughput: one word per clock; the whole
// pipeline holds while the output register is full and not taken. Reset
// (synchronous, rst_n low) empties the pipeline and loads the configuration defaults.
module cosine_column_gain_correction
  import ccgc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream. in_tdata: pixel_in [7:0], column [20:8], zeros [23:21].
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Result stream. out_tdata: pixel_out [7:0].
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must change them only while the pipeline is
  // empty, which the block does not enforce; every stage reads them directly.
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] strength_r;
  logic [CFG_W-1:0] width_r;
  logic [COL_W-1:0] start_column_r;
  logic [LW_W-1:0]  end_column_r;
  logic [LW_W-1:0]  line_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r     <= 16'd4096;
      width_r        <= 16'd2731;
      start_column_r <= '0;
      end_column_r   <= '0;
      line_width_r   <= 14'd8192;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STRENGTH:     strength_r     <= cfg_wdata;
        REG_WIDTH:        width_r        <= cfg_wdata;
        REG_START_COLUMN: start_column_r <= cfg_wdata[COL_W-1:0];
        REG_END_COLUMN:   end_column_r   <= cfg_wdata[LW_W-1:0];
        REG_LINE_WIDTH:   line_width_r   <= cfg_wdata[LW_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived settings: the effective line width, the end of the active range,
  // the cosine center and the magnitude of the width.
  logic [LW_W-1:0]  lw;
  logic [LW_W-1:0]  end_col;
  logic [COL_W-1:0] half_lw;
  logic [AW_W-1:0]  aw;
  logic             div_mode;

  assign lw = (line_width_r > LW_W'(LW_LIMIT)) ? LW_W'(LW_LIMIT) : line_width_r;
  assign end_col = ((end_column_r == '0) || (end_column_r > lw)) ? lw : end_column_r;
  assign half_lw = lw[LW_W-1:1];
  assign aw = width_r[CFG_W-1] ? (~width_r + 16'd1) : width_r;
  // A positive width divides by the cosine; zero or negative multiplies.
  assign div_mode = !width_r[CFG_W-1] && (width_r != '0);

  // The whole pipeline advances together whenever the output register can
  // take a word, so a stall never drops or duplicates anything.
  logic en;
  logic out_v_r;
  logic [PIX_W-1:0] out_pix_r;

  assign en        = !out_v_r || out_tready;
  assign in_tready = en;

  // ---------------------------------------------------------------------------
  // Stage T0: range check and distance from the line center.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] in_pix;
  logic [COL_W-1:0] in_col;
  logic             in_active;
  logic [D_W-1:0]   in_d;

  assign in_pix = in_tdata[PIX_W-1:0];
  assign in_col = in_tdata[PIX_W +: COL_W];
  assign in_active = (lw != '0) && (in_col >= start_column_r) &&
                     ({1'b0, in_col} < end_col);
  assign in_d = (in_col >= half_lw) ? (in_col - half_lw) : (half_lw - in_col);

  logic             t0_v_r;
  px_side_t         t0_side_r;
  logic [D_W-1:0]   t0_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_v_r <= 1'b0;
    end else if (en) begin
      t0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t0_side_r.pix    <= in_pix;
      t0_side_r.bypass <= !in_active;
      t0_d_r           <= in_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage T1: phase numerator d * |width| * 4. Within the active range the
  // phase quotient never exceeds 65536, so the upper numerator bits start the
  // divider already reduced below the line width.
  // ---------------------------------------------------------------------------
  logic [D_W+AW_W-1:0] num_prod;
  logic                t1_v_r;
  px_side_t            t1_side_r;
  logic [NUM_W-1:0]    t1_num_r;

  assign num_prod = t0_d_r * aw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r <= 1'b0;
    end else if (en) begin
      t1_v_r <= t0_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_side_r <= t0_side_r;
      t1_num_r  <= {num_prod, 2'b00};
    end
  end

  // ---------------------------------------------------------------------------
  // Phase divider: numerator / line width, 17 quotient bits.
  // ---------------------------------------------------------------------------
  logic                pd_v;
  logic [PHASE_QW-1:0] pd_quo;
  logic [$bits(px_side_t)-1:0] pd_side;

  ccgc_div_pipe #(
    .QW (PHASE_QW),
    .RW (LW_W),
    .SW ($bits(px_side_t))
  ) u_phase_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t1_v_r),
    .in_rem    (t1_num_r[NUM_W-1:PHASE_QW]),
    .in_low    (t1_num_r[PHASE_QW-1:0]),
    .in_div    (lw),
    .in_side   (t1_side_r),
    .out_valid (pd_v),
    .out_quo   (pd_quo),
    .out_side  (pd_side)
  );

  // ---------------------------------------------------------------------------
  // Cosine of the phase, taken modulo one turn.
  // ---------------------------------------------------------------------------
  logic                        cs_v;
  logic [G_W-1:0]              cs_g;
  logic                        cs_pos;
  logic [$bits(px_side_t)-1:0] cs_side_raw;
  px_side_t                    cs_side;

  ccgc_cos_pipe #(
    .SW ($bits(px_side_t))
  ) u_cos (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pd_v),
    .in_p      (pd_quo[15:0]),
    .in_side   (pd_side),
    .out_valid (cs_v),
    .out_g     (cs_g),
    .out_pos   (cs_pos),
    .out_side  (cs_side_raw)
  );

  assign cs_side = px_side_t'(cs_side_raw);

  // ---------------------------------------------------------------------------
  // Stage T2: multiply-path gain (strength << 4) * G >> 16, and the overflow
  // test of the divide path. A cosine at or below zero passes the pixel.
  // ---------------------------------------------------------------------------
  logic [CFG_W+G_W-1:0] mg_prod;
  logic                 t2_v_r;
  logic [G_W-1:0]       t2_g_r;
  gain_side_t           t2_side_r;

  assign mg_prod = strength_r * cs_g;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t2_v_r <= 1'b0;
    end else if (en) begin
      t2_v_r <= cs_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_g_r           <= cs_g;
      t2_side_r.pix    <= cs_side.pix;
      t2_side_r.bypass <= cs_side.bypass || !cs_pos;
      // strength << 20 / G overflows 24 bits exactly when strength >> 4 >= G.
      t2_side_r.sat    <= ({5'b0, strength_r[CFG_W-1:4]} >= cs_g);
      t2_side_r.mgain  <= mg_prod[MGAIN_W+11:12];
    end
  end

  // ---------------------------------------------------------------------------
  // Gain divider: (strength << 20) / G, 24 quotient bits.
  // ---------------------------------------------------------------------------
  logic                          gd_v;
  logic [GAIN_QW-1:0]            gd_quo;
  logic [$bits(gain_side_t)-1:0] gd_side_raw;
  gain_side_t                    gd_side;

  ccgc_div_pipe #(
    .QW (GAIN_QW),
    .RW (G_W),
    .SW ($bits(gain_side_t))
  ) u_gain_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (t2_v_r),
    .in_rem    ({5'b0, strength_r[CFG_W-1:4]}),
    .in_low    ({strength_r[3:0], 20'b0}),
    .in_div    (t2_g_r),
    .in_side   (t2_side_r),
    .out_valid (gd_v),
    .out_quo   (gd_quo),
    .out_side  (gd_side_raw)
  );

  assign gd_side = gain_side_t'(gd_side_raw);

  // ---------------------------------------------------------------------------
  // Stage T3: pick the gain and scale the pixel.
  // ---------------------------------------------------------------------------
  logic [GAIN_W-1:0]       gain;
  logic [PIX_W+GAIN_W-1:0] pix_prod;
  logic                    t3_v_r;
  logic [PIX_W-1:0]        t3_pix_r;
  logic                    t3_bypass_r;
  logic [PIX_W+GAIN_W-1:0] t3_prod_r;

  always_comb begin
    if (div_mode) begin
      gain = gd_side.sat ? GAIN_MAX : gd_quo;
    end else begin
      gain = {{(GAIN_W-MGAIN_W){1'b0}}, gd_side.mgain};
    end
  end

  assign pix_prod = gd_side.pix * gain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t3_v_r <= 1'b0;
    end else if (en) begin
      t3_v_r <= gd_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_pix_r    <= gd_side.pix;
      t3_bypass_r <= gd_side.bypass;
      t3_prod_r   <= pix_prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: drop the 16 fraction bits and saturate to 255.
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0] out_pix_nxt;

  always_comb begin
    if (t3_bypass_r) begin
      out_pix_nxt = t3_pix_r;
    end else if (t3_prod_r[PIX_W+GAIN_W-1:24] != '0) begin
      out_pix_nxt = PIX_MAX;
    end else begin
      out_pix_nxt = t3_prod_r[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= t3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;

endmodule
